### rtl/core/assert_macros.svh
// Assertion macros shared by the stencil residual RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### rtl/core/ksr_pkg.sv
// Package for the stencil residual block: widths, codes, stencil weights, payload types.
// Depends on nothing; imported by ksr_ctrl, ksr_dp and ks_stencil_residual.
`default_nettype none

package ksr_pkg;

    localparam int TAPS      = 7;
    localparam int HOLD      = TAPS - 1;
    localparam int SAMPLE_W  = 16;
    localparam int RES_W     = 48;
    localparam int SCALE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int FILL_W    = 3;

    // Stencil sums, pre-scaled by the constant parts of their weights.
    localparam int SUM_W     = 32;
    localparam int LAP_W     = 29;
    localparam int HYP_W     = 30;
    localparam int GMAG_W    = 22;
    localparam int GSQ_W     = 2 * GMAG_W;
    localparam int GSQ_HALF  = GMAG_W;
    localparam int LAP_MUL   = 5;
    localparam int HYP_MUL   = 75;

    // Shared multiplier and accumulator.
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 80;
    localparam int MAG_W     = ACC_W - 1;
    localparam int LAP_SHIFT = 15;
    localparam int HYP_SHIFT = 16;
    localparam int GHI_SHIFT = GSQ_HALF;
    localparam int MUL_OPS   = 5;
    localparam int MUL_IDX_W = $clog2(MUL_OPS);

    // The divisor is 225 * 2^29: shift first, then divide by 225.
    localparam int ROUND_SHIFT = 29;
    localparam int DIVISOR     = 225;
    localparam int REM_W       = 8;
    localparam int DIV_W       = 50;
    localparam int DIV_STEP    = 5;
    localparam int DIV_ITERS   = DIV_W / DIV_STEP;
    localparam int CNT_W       = $clog2(DIV_ITERS);

    localparam logic [MAG_W-1:0] HALF_D  = MAG_W'(DIVISOR) << (ROUND_SHIFT - 1);
    localparam logic [REM_W:0]   DIV_K   = (REM_W + 1)'(DIVISOR);
    localparam logic [DIV_W-1:0] NEG_MAG = DIV_W'(1) << (RES_W - 1);
    localparam logic [DIV_W-1:0] MAX_POS = NEG_MAG - DIV_W'(1);

    localparam int LAP_C [TAPS] = '{2, -27, 270, -490, 270, -27, 2};
    localparam int HYP_C [TAPS] = '{-1, 12, -39, 56, -39, 12, -1};
    localparam int GRD_C [TAPS] = '{-1, 9, -45, 0, 45, -9, 1};

    typedef logic [2:0] op_t;
    localparam op_t OP_NONE = 3'd0;
    localparam op_t OP_GSQ  = 3'd1;
    localparam op_t OP_LAP  = 3'd2;
    localparam op_t OP_HYP  = 3'd3;
    localparam op_t OP_GLO  = 3'd4;
    localparam op_t OP_GHI  = 3'd5;

    localparam op_t MUL_SEQ [MUL_OPS] = '{OP_GSQ, OP_LAP, OP_HYP, OP_GLO, OP_GHI};

    localparam logic [CFG_IDX_W-1:0] REG_FORM_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE2    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE4    = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE2_RST = 32'd107374;
    localparam logic [SCALE_W-1:0] SCALE4_RST = 32'd175922;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } ksr_in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        logic                    saturated;
    } ksr_out_t;

    typedef struct packed {
        logic take;
        op_t  op;
        logic mag;
        logic rnd;
        logic div;
        logic out;
    } ksr_cmd_t;

endpackage

`default_nettype wire

### rtl/core/ksr_dp.sv
// Datapath of the stencil residual block: window, stencils, multiply-accumulate,
// rounding, divide by 225 and saturation. Depends on ksr_pkg.
`default_nettype none

module ksr_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ksr_pkg::ksr_cmd_t             cmd,
    input  logic signed [ksr_pkg::SAMPLE_W-1:0] sample,
    input  logic                          form_mode,
    input  logic [ksr_pkg::SCALE_W-1:0]   scale2,
    input  logic [ksr_pkg::SCALE_W-1:0]   scale4,
    output ksr_pkg::ksr_out_t             out_data
);
    import ksr_pkg::*;

    logic signed [SAMPLE_W-1:0] win_reg [HOLD];
    logic signed [SAMPLE_W-1:0] tap [TAPS];
    logic signed [SUM_W-1:0]    lap_sum, hyp_sum, grd_sum, grd_abs;
    logic signed [LAP_W-1:0]    lap5_reg;
    logic signed [HYP_W-1:0]    hyp75_reg;
    logic [GMAG_W-1:0]          gmag_reg;
    logic [GSQ_W-1:0]           gsq_reg;

    logic [SCALE_W-1:0]                mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [SCALE_W+MUL_B_W:0]   prod_full;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [ACC_W-1:0]           prod_ext;
    op_t                               op_reg;
    logic signed [ACC_W-1:0]           acc_reg;

    logic                 neg_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [MAG_W-1:0]     rounded;
    logic [DIV_W-1:0]     num_reg, num_v;
    logic [REM_W-1:0]     rem_reg, rem_v;
    logic [REM_W:0]       trial;

    logic                 sat_v;
    logic [DIV_W-1:0]     qmag_v;
    logic [RES_W-1:0]     res_v;
    ksr_out_t             out_reg;

    // Seven-point stencils over the held window plus the incoming sample.
    always_comb begin
        for (int k = 0; k < HOLD; k++) begin
            tap[k] = win_reg[k];
        end
        tap[HOLD] = sample;
        lap_sum = '0;
        hyp_sum = '0;
        grd_sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            lap_sum = lap_sum + SUM_W'(LAP_C[k]) * SUM_W'(tap[k]);
            hyp_sum = hyp_sum + SUM_W'(HYP_C[k]) * SUM_W'(tap[k]);
            grd_sum = grd_sum + SUM_W'(GRD_C[k]) * SUM_W'(tap[k]);
        end
        grd_abs = grd_sum[SUM_W-1] ? -grd_sum : grd_sum;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            for (int k = 0; k < HOLD - 1; k++) begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[HOLD-1] <= sample;
            lap5_reg  <= LAP_W'(lap_sum * SUM_W'(LAP_MUL));
            hyp75_reg <= HYP_W'(hyp_sum * SUM_W'(HYP_MUL));
            gmag_reg  <= grd_abs[GMAG_W-1:0];
        end
    end

    // Operand selection for the shared 32 x 32 multiplier.
    always_comb begin
        unique case (cmd.op)
            OP_GSQ: begin
                mul_a = SCALE_W'(gmag_reg);
                mul_b = MUL_B_W'(gmag_reg);
            end
            OP_LAP: begin
                mul_a = scale2;
                mul_b = MUL_B_W'(lap5_reg);
            end
            OP_HYP: begin
                mul_a = scale4;
                mul_b = MUL_B_W'(hyp75_reg);
            end
            OP_GLO: begin
                mul_a = form_mode ? scale2 : '0;
                mul_b = MUL_B_W'(gsq_reg[GSQ_HALF-1:0]);
            end
            OP_GHI: begin
                mul_a = form_mode ? scale2 : '0;
                mul_b = MUL_B_W'(gsq_reg[GSQ_W-1:GSQ_HALF]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_full = $signed({1'b0, mul_a}) * mul_b;
        prod_ext  = ACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_NONE;
        end else begin
            op_reg <= cmd.op;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[PROD_W-1:0];
        if (cmd.take) begin
            acc_reg <= '0;
        end else begin
            unique case (op_reg)
                OP_GSQ: gsq_reg <= prod_reg[GSQ_W-1:0];
                OP_LAP: acc_reg <= acc_reg + (prod_ext <<< LAP_SHIFT);
                OP_HYP: acc_reg <= acc_reg + (prod_ext <<< HYP_SHIFT);
                OP_GLO: acc_reg <= acc_reg + prod_ext;
                OP_GHI: acc_reg <= acc_reg + (prod_ext <<< GHI_SHIFT);
                default: ;
            endcase
        end
    end

    // Magnitude, round half away from zero, then the 2^29 part of the divisor.
    assign rounded = mag_reg + HALF_D;

    // Five quotient bits per cycle of the restoring divide by 225.
    always_comb begin
        rem_v = rem_reg;
        num_v = num_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial = {rem_v, num_v[DIV_W-1]};
            num_v = {num_v[DIV_W-2:0], 1'b0};
            if (trial >= DIV_K) begin
                trial    = trial - DIV_K;
                num_v[0] = 1'b1;
            end
            rem_v = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mag) begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
        end
        if (cmd.rnd) begin
            num_reg <= DIV_W'(rounded >> ROUND_SHIFT);
            rem_reg <= '0;
        end else if (cmd.div) begin
            num_reg <= num_v;
            rem_reg <= rem_v;
        end
    end

    // Clip the quotient magnitude to the signed 48-bit range and apply the sign.
    always_comb begin
        if (neg_reg) begin
            sat_v  = num_reg > NEG_MAG;
            qmag_v = sat_v ? NEG_MAG : num_reg;
            res_v  = RES_W'(-qmag_v);
        end else begin
            sat_v  = num_reg > MAX_POS;
            qmag_v = sat_v ? MAX_POS : num_reg;
            res_v  = RES_W'(qmag_v);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out) begin
            out_reg.residual  <= res_v;
            out_reg.saturated <= sat_v;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

### rtl/core/ksr_ctrl.sv
// Controller of the stencil residual block: fill count, step sequencing, output valid.
// Depends on ksr_pkg; drives the datapath through ksr_cmd_t.
`default_nettype none

module ksr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              restart,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ksr_pkg::ksr_cmd_t cmd
);
    import ksr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ABS   = 3'd3;
    localparam logic [2:0] S_RND   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FILL_W-1:0] fill_reg, fill_next, fill_eff;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.op       = OP_NONE;
        fill_eff     = restart ? '0 : fill_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (fill_eff < FILL_W'(HOLD)) begin
                        fill_next = fill_eff + FILL_W'(1);
                    end else begin
                        fill_next  = fill_eff;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                cmd.op = MUL_SEQ[cnt_reg[MUL_IDX_W-1:0]];
                if (cnt_reg == CNT_W'(MUL_OPS - 1)) begin
                    state_next = S_DRAIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_ABS;
            end
            S_ABS: begin
                cmd.mag    = 1'b1;
                state_next = S_RND;
            end
            S_RND: begin
                cmd.rnd    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div = 1'b1;
                if (cnt_reg == CNT_W'(DIV_ITERS - 1)) begin
                    state_next = S_OUT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### rtl/core/ks_stencil_residual.sv
// A sample that completes a seven-sample neighborhood gives its result on m_valid after
// the multiply, drain, magnitude, round, divide and output steps; filling samples only
// enter the window. No new sample is taken until the result is loaded, after five passes
// through the shared 32 x 32 multiplier and ten 5-bit steps of the divide by 225.
// Reset (aresetn low, synchronous): window empty, no result pending, form_mode 0,
// scale2 and scale4 at their default spacings.
`default_nettype none
`include "assert_macros.svh"

module ks_stencil_residual (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Sample requests.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ksr_pkg::ksr_in_t                    s_data,
    // Result requests.
    output logic                                m_valid,
    input  logic                                m_ready,
    output ksr_pkg::ksr_out_t                   m_data,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ksr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ksr_pkg::SCALE_W-1:0]         cfg_data
);
    import ksr_pkg::*;

    // Configuration registers, read directly by the datapath. Writes are always taken;
    // the host must write them only while no sample is in flight; this is not enforced.
    logic               form_mode_reg;
    logic [SCALE_W-1:0] scale2_reg;
    logic [SCALE_W-1:0] scale4_reg;

    ksr_cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            form_mode_reg <= 1'b0;
            scale2_reg    <= SCALE2_RST;
            scale4_reg    <= SCALE4_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FORM_MODE: form_mode_reg <= cfg_data[0];
                REG_SCALE2:    scale2_reg    <= cfg_data;
                REG_SCALE4:    scale4_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // The controller counts the window fill, accepts samples only when no
    // computation is running, and sequences the datapath one step at a time.
    ksr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .restart (s_data.restart),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the six-sample window, forms the three stencil sums
    // at accept time, accumulates scale2*L, scale4*H and the optional
    // half squared gradient term through one multiplier, rounds, divides and
    // saturates. The output register lets a new sample be accepted while the
    // previous result still waits downstream.
    ksr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sample    (s_data.sample),
        .form_mode (form_mode_reg),
        .scale2    (scale2_reg),
        .scale4    (scale4_reg),
        .out_data  (m_data)
    );

    // The output register is only loaded when it is empty or being drained.
    `ASSERT_CLK(a_out_no_overwrite, aclk, aresetn, cmd.out |-> (!m_valid || m_ready), "result overwritten before it was taken")

    // No new sample enters while the multiplier sequence is running.
    `ASSERT_NEVER(a_busy_no_accept, aclk, aresetn, (cmd.op != OP_NONE) && s_ready, "sample accepted during multiply sequence")

    // With 16-bit samples and 32-bit scales the result stays far inside 48 bits.
    `ASSERT_CLK(a_no_saturation, aclk, aresetn, m_valid |-> !m_data.saturated, "residual saturated although operands cannot reach the limit")

endmodule

`default_nettype wire

### test/ks_stencil_residual_tb.sv
// Self-checking testbench for ks_stencil_residual: directed and random padded grid sequences,
// with a scoreboard that predicts each stencil residual exactly. Uses ksr_pkg and the block.
`timescale 1ns / 1ps

module ks_stencil_residual_tb;

    import ksr_pkg::*;

    // Run shape.
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 30;      // longer than the result latency
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 115;
    localparam int MAX_PTS = 48;
    localparam int LONG_STALL = 600;
    localparam int STALL_PHASE = 6;

    // Index 3 decodes to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Integer stencils over x[-3..+3]: second derivative times 180, fourth derivative
    // times 6, first derivative times 60.
    localparam int D2_WT [7] = '{2, -27, 270, -490, 270, -27, 2};
    localparam int D4_WT [7] = '{-1, 12, -39, 56, -39, 12, -1};
    localparam int D1_WT [7] = '{-1, 9, -45, 0, 45, -9, 1};

    // The exact raw result is a fraction with a common denominator. The three terms
    // are brought onto it by these gains.
    localparam int LAP_GAIN = 163840;
    localparam int HYP_GAIN = 4915200;
    localparam logic signed [127:0] ROUND_DIV = 128'sd120795955200;
    localparam logic signed [127:0] HALF_DIV = 128'sd60397977600;
    localparam logic signed [127:0] POS_LIMIT = 128'sd140737488355327;
    localparam logic signed [127:0] NEG_LIMIT = 128'sd140737488355328;

    typedef enum int { SHAPE_NOISE, SHAPE_EXTREME, SHAPE_SMOOTH } shape_e;
    typedef enum int { SCALE_ZERO, SCALE_FULL, SCALE_WIDE, SCALE_LOW } scale_e;

    // Block ports. Every input holds a known value from time zero.
    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    ksr_in_t              s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    ksr_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0]   cfg_data = '0;

    // Predictor state: its own copy of the registers and of the sample window.
    logic               form_q = 1'b0;
    logic [SCALE_W-1:0] scale2_q = 32'd107374;
    logic [SCALE_W-1:0] scale4_q = 32'd175922;
    logic signed [15:0] nbhd_win [6];
    int                 nbhd_fill = 0;

    ksr_in_t  sample_queue [$];   // sample requests waiting to be offered
    ksr_out_t residual_due [$];   // predicted results, oldest first

    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    bit  in_taken = 1'b0;
    bit  long_stall_req = 1'b0;
    int  stall_left = 0;
    int  queued_items = 0;
    int  samples_taken = 0;
    int  results_checked = 0;
    int  config_writes = 0;
    int  mismatches = 0;
    int  cycle_count = 0;

    ks_stencil_residual u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Works out what one accepted sample request produces. Filling samples only
    // enter the window; from the seventh sample on, each one completes a
    // neighborhood and gives one residual for its center.
    task automatic predict_residual(input ksr_in_t req);
        logic signed [15:0]  taps [7];
        longint              d2;
        longint              d4;
        longint              d1;
        logic signed [127:0] w_s2;
        logic signed [127:0] w_s4;
        logic signed [127:0] num;
        logic signed [127:0] mag;
        logic signed [127:0] quo;
        ksr_out_t            res;
        if (req.restart) begin
            for (int k = 0; k < 6; k++) nbhd_win[k] = '0;
            nbhd_fill = 0;
        end
        if (nbhd_fill < 6) begin
            nbhd_win[nbhd_fill] = req.sample;
            nbhd_fill++;
            return;
        end
        for (int k = 0; k < 6; k++) taps[k] = nbhd_win[k];
        taps[6] = req.sample;
        d2 = 0;
        d4 = 0;
        d1 = 0;
        for (int k = 0; k < 7; k++) begin
            d2 += D2_WT[k] * taps[k];
            d4 += D4_WT[k] * taps[k];
            d1 += D1_WT[k] * taps[k];
        end
        for (int k = 0; k < 5; k++) nbhd_win[k] = nbhd_win[k + 1];
        nbhd_win[5] = req.sample;

        // Everything is carried exactly in 128 bits; the scales are unsigned.
        w_s2 = {96'd0, scale2_q};
        w_s4 = {96'd0, scale4_q};
        num = w_s2 * d2 * LAP_GAIN + w_s4 * d4 * HYP_GAIN;
        if (form_q) begin
            num += w_s2 * d1 * d1;
        end

        // Round half away from zero on the magnitude, then clip to 48 bits.
        mag = (num < 0) ? -num : num;
        quo = (mag + HALF_DIV) / ROUND_DIV;
        res.saturated = 1'b0;
        if (num < 0) begin
            if (quo > NEG_LIMIT) begin
                quo = NEG_LIMIT;
                res.saturated = 1'b1;
            end
            quo = -quo;
        end else if (quo > POS_LIMIT) begin
            quo = POS_LIMIT;
            res.saturated = 1'b1;
        end
        res.residual = quo[RES_W-1:0];
        residual_due.push_back(res);
    endtask

    // Sample channel driver. A new request goes out only when the previous one was
    // taken or none was pending, so valid never drops before its handshake.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_data <= sample_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Sample channel monitor: every accepted request goes through the predictor.
    always @(posedge aclk) begin
        in_taken = 1'b0;
        if (aresetn && s_valid && s_ready) begin
            in_taken = 1'b1;
            predict_residual(s_data);
            samples_taken++;
        end
    end

    // Result channel ready. A long hold-off, once asked for, is counted down here
    // while the sender keeps offering, so the block backs up and stalls its input.
    always @(negedge aclk) begin
        if (long_stall_req) begin
            stall_left = LONG_STALL;
            long_stall_req = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Result channel monitor: compare each result with the oldest prediction.
    always @(posedge aclk) begin
        ksr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (residual_due.size() == 0) begin
                $error("unexpected result: residual %0d saturated %0b",
                       m_data.residual, m_data.saturated);
                mismatches++;
            end else begin
                want = residual_due.pop_front();
                if (m_data.residual !== want.residual) begin
                    $error("residual: expected %0d, got %0d", want.residual, m_data.residual);
                    mismatches++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, m_data.saturated);
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     residual_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One register write on the configuration channel. The predictor takes the
    // new value only once the request has been accepted.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_FORM_MODE: begin
                form_q = val[0];
            end
            REG_SCALE2: begin
                scale2_q = val;
            end
            REG_SCALE4: begin
                scale4_q = val;
            end
            default: begin
            end
        endcase
        config_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input logic signed [15:0] value, input logic restart_bit);
        ksr_in_t req;
        req.sample = value;
        req.restart = restart_bit;
        sample_queue.push_back(req);
        queued_items++;
    endtask

    // Waits until every request is sent and every result is back, then lets the
    // block run for longer than its latency so no filling sample is still in flight.
    task automatic wait_idle();
        while (sample_queue.size() != 0 || s_valid || residual_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] next_value(input shape_e shape,
                                                      input logic signed [15:0] prev);
        int v;
        case (shape)
            SHAPE_NOISE: begin
                return 16'($urandom);
            end
            SHAPE_EXTREME: begin
                case ($urandom_range(4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'($urandom);
                endcase
            end
            default: begin
                // A smooth field: small steps, held inside the Q3.12 range.
                v = int'(prev) + int'($urandom_range(512)) - 256;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return 16'(v);
            end
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale(input scale_e kind);
        case (kind)
            SCALE_ZERO: return '0;
            SCALE_FULL: return '1;
            SCALE_WIDE: return $urandom;
            default: return $urandom_range(32'h0010_0000);
        endcase
    endfunction

    // One periodic grid of pts points, padded with three ghost samples at each
    // end, the first sample marked as a restart. A broken sequence is cut short.
    task automatic queue_grid(input int pts, input shape_e shape, input bit broken);
        logic signed [15:0] grid [MAX_PTS];
        logic signed [15:0] prev;
        int                 total;
        int                 stop_at;
        prev = 16'($urandom);
        for (int i = 0; i < pts; i++) begin
            grid[i] = next_value(shape, prev);
            prev = grid[i];
        end
        total = pts + 6;
        stop_at = broken ? $urandom_range(total - 1, 1) : total;
        for (int i = 0; i < stop_at; i++) begin
            queue_sample(grid[(i - 3 + 3 * pts) % pts], i == 0);
        end
    endtask

    // Mostly well-formed padded grids with random content, some cut short, and
    // some bursts of raw samples with random restarts.
    task automatic queue_random_phase();
        int start;
        int pick;
        int pts;
        start = queued_items;
        while (queued_items - start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            pts = ($urandom_range(9) == 0) ? $urandom_range(MAX_PTS, 17)
                                           : $urandom_range(16, 1);
            if (pick < 80) begin
                queue_grid(pts, shape_e'($urandom_range(2)), 1'b0);
            end else if (pick < 90) begin
                queue_grid(pts, shape_e'($urandom_range(2)), 1'b1);
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    queue_sample(16'($urandom), $urandom_range(7) == 0);
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, first at the reset settings: alternating full-scale
        // samples, then a restart in the middle of filling followed by a ramp.
        src_idle_pct = 8;
        sink_idle_pct = 54;
        for (int i = 0; i < 8; i++) begin
            queue_sample(i[0] ? 16'sh8000 : 16'sh7FFF, i == 0);
        end
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sd100, 1'b0);
        queue_sample(-16'sd100, 1'b0);
        for (int i = 0; i < 7; i++) begin
            queue_sample(16'(-12288 + 4096 * i), i == 0);
        end
        wait_idle();

        // Then the gradient form with both scales at full range, upper data bits
        // set on the one-bit register, and a write to the unused index. Two
        // positive spikes in a negative floor drive all three stencils hard.
        write_reg(REG_FORM_MODE, 32'hFFFF_FFFF);
        write_reg(REG_SCALE2, '1);
        write_reg(REG_SCALE4, '1);
        write_reg(REG_UNUSED, 32'h0000_0000);
        for (int i = 0; i < 9; i++) begin
            queue_sample((i == 3 || i == 7) ? 16'sh7FFF : ((i == 8) ? 16'sh0000 : 16'sh8000),
                         i == 0);
        end
        wait_idle();

        // Random phases. Each starts from an idle block with fresh settings, and
        // the idling pattern moves from a slow receiver to a slow sender to none.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                src_idle_pct = 8;
                sink_idle_pct = 54;
            end else if (p < 6) begin
                src_idle_pct = 54;
                sink_idle_pct = 8;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            write_reg(REG_FORM_MODE, {31'($urandom), p[0]});
            write_reg(REG_SCALE2, pick_scale(scale_e'(p % 4)));
            write_reg(REG_SCALE4, pick_scale(scale_e'((p + 1) % 4)));
            if (p == 4) begin
                write_reg(REG_UNUSED, $urandom);
            end
            queue_random_phase();
            if (p == STALL_PHASE) begin
                long_stall_req = 1'b1;
            end
            wait_idle();
        end

        $display("Checked %0d residuals from %0d sample requests across %0d register writes.",
                 results_checked, samples_taken, config_writes);
        $display("Both forms, zero and full-range scales, mid-fill restarts and a %0d-cycle %s",
                 LONG_STALL, "result hold-off were exercised.");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### ks_stencil_residual.f
+incdir+rtl/core
rtl/core/ksr_pkg.sv
rtl/core/ksr_dp.sv
rtl/core/ksr_ctrl.sv
rtl/core/ks_stencil_residual.sv
test/ks_stencil_residual_tb.sv
